@@ hdl/cdb_pkg.sv @@
package cdb_pkg;

  // Word width of a stored value; the payload structs below are fixed to it.
  localparam int VALUE_WIDTH = 32;

  // Width of the capacity field as written through the register port.
  localparam int CAP_FIELD_W = 11;

  // Register port: byte address bits and the register index.
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam bit REG_CAPACITY = 1'b0;

  // Operation codes.
  localparam logic [2:0] OP_PUSH_HEAD = 3'd0;
  localparam logic [2:0] OP_PUSH_TAIL = 3'd1;
  localparam logic [2:0] OP_POP_HEAD  = 3'd2;
  localparam logic [2:0] OP_POP_TAIL  = 3'd3;
  localparam logic [2:0] OP_QUERY     = 3'd4;

  typedef struct packed {
    logic [2:0]                    opcode;
    logic signed [VALUE_WIDTH-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic                          accepted;
    logic signed [VALUE_WIDTH-1:0] head_value;
    logic signed [VALUE_WIDTH-1:0] tail_value;
    logic                          is_empty;
    logic                          is_full;
  } out_item_t;

  // Per-beat status carried from the pointer logic to the result stage.
  typedef struct packed {
    logic valid;
    logic accepted;
    logic is_empty;
    logic is_full;
    logic fwd_head;
    logic fwd_tail;
  } res_stat_t;

endpackage

@@ hdl/cdb_store.sv @@
module cdb_store
  import cdb_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  input  logic [VALUE_WIDTH-1:0]         wr_data,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr_b,
  output logic [VALUE_WIDTH-1:0]         rd_data_a,
  output logic [VALUE_WIDTH-1:0]         rd_data_b
);

  logic [VALUE_WIDTH-1:0] mem [STORE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_a_r;
  logic [VALUE_WIDTH-1:0] rd_b_r;

  // One write port, two registered read ports; a read of the entry being
  // written returns the old word, and the caller forwards around that.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

@@ hdl/cdb_ctrl.sv @@
module cdb_ctrl
  import cdb_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  in_item_t                       item,
  input  logic                           cap_wr,
  input  logic [CAP_FIELD_W-1:0]         cap_wdata,
  output logic [$clog2(STORE_DEPTH+1)-1:0] cap_value,
  output logic                           wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  output logic [$clog2(STORE_DEPTH)-1:0] rd_addr_head,
  output logic [$clog2(STORE_DEPTH)-1:0] rd_addr_tail,
  output res_stat_t                      stat,
  output logic [VALUE_WIDTH-1:0]         fwd_data
);

  localparam int PW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  res_stat_t     stat_r, stat_nxt;
  logic [VALUE_WIDTH-1:0] fwd_data_r;

  logic          full_now;
  logic          empty_now;
  logic          ok;
  logic [PW-1:0] tail_last;
  logic [31:0]   cap_wide;

  function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p,
                                             input logic [CW-1:0] c);
    logic [CW-1:0] cm1;
    cm1 = c - 1'b1;
    return (p == '0) ? cm1[PW-1:0] : p - 1'b1;
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p,
                                             input logic [CW-1:0] c);
    logic [SW-1:0] pp1;
    pp1 = SW'(p) + 1'b1;
    return (pp1 >= SW'(c)) ? '0 : pp1[PW-1:0];
  endfunction

  assign full_now  = (count_r >= cap_r);
  assign empty_now = (count_r == '0);
  assign cap_wide  = 32'(cap_wdata);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ok        = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    case (item.opcode)
      OP_PUSH_HEAD: begin
        if (!full_now) begin
          head_nxt  = wrap_dec(head_r, cap_r);
          wr_addr   = head_nxt;
          wr_en     = go;
          count_nxt = count_r + 1'b1;
          ok        = 1'b1;
        end
      end
      OP_PUSH_TAIL: begin
        if (!full_now) begin
          wr_addr   = tail_r;
          tail_nxt  = wrap_inc(tail_r, cap_r);
          wr_en     = go;
          count_nxt = count_r + 1'b1;
          ok        = 1'b1;
        end
      end
      OP_POP_HEAD: begin
        if (!empty_now) begin
          head_nxt  = wrap_inc(head_r, cap_r);
          count_nxt = count_r - 1'b1;
          ok        = 1'b1;
        end
      end
      OP_POP_TAIL: begin
        if (!empty_now) begin
          tail_nxt  = wrap_dec(tail_r, cap_r);
          count_nxt = count_r - 1'b1;
          ok        = 1'b1;
        end
      end
      OP_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    tail_last    = wrap_dec(tail_nxt, cap_r);
    rd_addr_head = head_nxt;
    rd_addr_tail = tail_last;

    stat_nxt.valid    = go;
    stat_nxt.accepted = ok;
    stat_nxt.is_empty = (count_nxt == '0);
    stat_nxt.is_full  = (count_nxt >= cap_r);
    stat_nxt.fwd_head = wr_en && (wr_addr == head_nxt);
    stat_nxt.fwd_tail = wr_en && (wr_addr == tail_last);

    if (cap_wide == 32'd0) begin
      cap_nxt = CW'(1);
    end else if (cap_wide > 32'(STORE_DEPTH)) begin
      cap_nxt = CW'(STORE_DEPTH);
    end else begin
      cap_nxt = cap_wide[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      cap_r   <= CW'(STORE_DEPTH);
      stat_r  <= '0;
    end else begin
      stat_r <= stat_nxt;
      if (cap_wr) begin
        cap_r   <= cap_nxt;
        head_r  <= '0;
        tail_r  <= '0;
        count_r <= '0;
      end else if (go) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      fwd_data_r <= item.push_value;
    end
  end

  assign cap_value = cap_r;
  assign stat      = stat_r;
  assign fwd_data  = fwd_data_r;

endmodule

@@ hdl/circular_deque_buffer_unit.sv @@
// Double-ended queue held in a ring of STORE_DEPTH words.
// Input channel: an operation beat (in_data: opcode and push_value) is taken
// at a rising edge where start is high and busy is low. Opcodes push at the
// head, push at the tail, pop at the head, pop at the tail, or only query.
// Result channel: every taken beat yields exactly one result beat on out_data,
// marked by out_valid for a single cycle in the cycle after the beat is taken.
// The result holds the accepted flag, the head and tail words (all ones when
// the deque is empty) and the empty and full flags after the operation.
// Throughput is one beat per cycle while busy is low: the pointer update and
// store write happen at the accepting edge, while the store's two read ports
// fetch the new head and tail words for the following cycle; a word written
// in the same edge is forwarded. The receiver cannot stall, so nothing is
// held back. Configuration: one register, capacity, at byte address 0 of an
// APB-style port. Writing it clamps the value to 1..STORE_DEPTH and empties
// the deque; busy is high during the access cycle of a write. Writes are
// expected only while no result is outstanding.
// Reset (synchronous, active low) empties the deque and sets the capacity to
// STORE_DEPTH; the store contents are not cleared and need no sweep.
module circular_deque_buffer_unit
  import cdb_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic                   go;
  logic                   cfg_wr;
  logic                   cap_wr;
  logic [CW-1:0]          cap_value;
  logic                   wr_en;
  logic [PW-1:0]          wr_addr;
  logic [PW-1:0]          rd_addr_head;
  logic [PW-1:0]          rd_addr_tail;
  logic [VALUE_WIDTH-1:0] rd_head;
  logic [VALUE_WIDTH-1:0] rd_tail;
  logic [VALUE_WIDTH-1:0] fwd_data;
  res_stat_t              stat;

  // The register port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cap_wr = cfg_wr && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(cap_value) : '0;

  // A register write resets the pointers, so no beat is taken alongside it.
  assign busy = cfg_wr;
  assign go   = start && !busy;

  cdb_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .item         (in_data),
    .cap_wr       (cap_wr),
    .cap_wdata    (pwdata[CAP_FIELD_W-1:0]),
    .cap_value    (cap_value),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_addr_head (rd_addr_head),
    .rd_addr_tail (rd_addr_tail),
    .stat         (stat),
    .fwd_data     (fwd_data)
  );

  cdb_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_data.push_value),
    .rd_addr_a (rd_addr_head),
    .rd_addr_b (rd_addr_tail),
    .rd_data_a (rd_head),
    .rd_data_b (rd_tail)
  );

  // Result stage: the store words arrive registered; when the same beat wrote
  // the entry that is now at the head or tail, the pushed word replaces the
  // stale read. An empty deque shows all ones on both words.
  always_comb begin
    out_valid           = stat.valid;
    out_data.accepted   = stat.accepted;
    out_data.is_empty   = stat.is_empty;
    out_data.is_full    = stat.is_full;
    if (stat.is_empty) begin
      out_data.head_value = '1;
      out_data.tail_value = '1;
    end else begin
      out_data.head_value = stat.fwd_head ? fwd_data : rd_head;
      out_data.tail_value = stat.fwd_tail ? fwd_data : rd_tail;
    end
  end

endmodule

@@ hdl/cdb_chk.sv @@
module cdb_chk
  import cdb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // Every taken beat produces its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("result missing after a taken beat");

  // No result appears without a beat taken in the cycle before.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a taken beat");

  // An empty deque reports all ones for both end words.
  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.head_value == '1 && out_data.tail_value == '1)
    else $error("empty deque shows a stored word");

  // Capacity is at least one, so empty and full never coincide.
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_empty && out_data.is_full))
    else $error("empty and full both set");

  // A query always succeeds.
  a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.opcode == OP_QUERY |=> out_data.accepted)
    else $error("query not accepted");

endmodule

bind circular_deque_buffer_unit cdb_chk u_cdb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ bench/circular_deque_buffer_unit_tb.sv @@
module circular_deque_buffer_unit_tb;
  import cdb_pkg::*;

  // The ring in the block is built at its default depth; the bench mirrors it.
  localparam int STORE_DEPTH = 1024;
  localparam int PW          = $clog2(STORE_DEPTH);

  // Opcodes that carry no operation. The block must refuse them and leave the
  // deque alone.
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  // The word reported for head and tail whenever the deque holds nothing.
  localparam logic signed [VALUE_WIDTH-1:0] EMPTY_WORD = '1;

  // Byte address of the capacity register: index times four.
  localparam logic [CFG_ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  // Lower bound on the random operation beats sent after the directed part.
  localparam int RANDOM_BEATS = 1600;

  // The watchdog ends the run after this many cycles in which no beat moved
  // on either channel and no register was written. The limit is many times
  // the longest planned gap, and so of the slowest correct pace.
  localparam int STALL_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  circular_deque_buffer_unit #(
    .STORE_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Deque predictor. It keeps its own copy of the ring, both pointers, the
  // entry count and the capacity in use. The head pointer names the head
  // entry, while the tail pointer names the slot just past the tail entry.
  // ---------------------------------------------------------------------------
  logic [VALUE_WIDTH-1:0] ring_store [STORE_DEPTH];
  int                     ring_head;
  int                     ring_tail;
  int                     ring_count;
  int                     ring_cap;

  function automatic int ptr_back(input int p);
    return (p == 0) ? ring_cap - 1 : p - 1;
  endfunction

  function automatic int ptr_fwd(input int p);
    return (p + 1 >= ring_cap) ? 0 : p + 1;
  endfunction

  // A capacity write keeps only the low eleven bits, clamps them to the legal
  // range and empties the deque. The ring keeps its words.
  function automatic void apply_capacity(input logic [CFG_DATA_W-1:0] value);
    int c;
    c = int'(value[CAP_FIELD_W-1:0]);
    if (c == 0) c = 1;
    if (c > STORE_DEPTH) c = STORE_DEPTH;
    ring_cap   = c;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
  endfunction

  // Applies one operation beat and returns the view of the deque after it.
  function automatic out_item_t deque_step(input in_item_t beat);
    out_item_t view;
    bit        ok;
    bit        was_full;
    bit        was_empty;
    was_full  = (ring_count >= ring_cap);
    was_empty = (ring_count == 0);
    ok        = 1'b0;
    case (beat.opcode)
      OP_PUSH_HEAD: begin
        if (!was_full) begin
          ring_head                 = ptr_back(ring_head);
          ring_store[PW'(ring_head)] = beat.push_value;
          ring_count++;
          ok = 1'b1;
        end
      end
      OP_PUSH_TAIL: begin
        if (!was_full) begin
          ring_store[PW'(ring_tail)] = beat.push_value;
          ring_tail                 = ptr_fwd(ring_tail);
          ring_count++;
          ok = 1'b1;
        end
      end
      OP_POP_HEAD: begin
        if (!was_empty) begin
          ring_head = ptr_fwd(ring_head);
          ring_count--;
          ok = 1'b1;
        end
      end
      OP_POP_TAIL: begin
        if (!was_empty) begin
          ring_tail = ptr_back(ring_tail);
          ring_count--;
          ok = 1'b1;
        end
      end
      OP_QUERY: ok = 1'b1;
      default:  ok = 1'b0;
    endcase
    view.accepted   = ok;
    view.is_empty   = (ring_count == 0);
    view.is_full    = (ring_count >= ring_cap);
    view.head_value = view.is_empty ? EMPTY_WORD : ring_store[PW'(ring_head)];
    view.tail_value = view.is_empty ? EMPTY_WORD : ring_store[PW'(ptr_back(ring_tail))];
    return view;
  endfunction

  // Views of the deque that the block still owes, oldest first. Every taken
  // operation beat pushes exactly one.
  out_item_t deque_view_q [$];
  int        mismatches;

  // ---------------------------------------------------------------------------
  // Result monitor. The block returns each result for one cycle only and the
  // bench cannot hold it off, so every strobe is checked at the edge that ends
  // its cycle. Reading inside the edge process sees the values from before
  // the edge, which keeps the check free of scheduling order.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [VALUE_WIDTH-1:0] want,
                               input logic [VALUE_WIDTH-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (deque_view_q.size() == 0) begin
        $error("result beat with no operation outstanding");
        mismatches++;
      end else begin
        want = deque_view_q.pop_front();
        compare_field("accepted", VALUE_WIDTH'(want.accepted),
                      VALUE_WIDTH'(out_data.accepted));
        compare_field("head_value", want.head_value, out_data.head_value);
        compare_field("tail_value", want.tail_value, out_data.tail_value);
        compare_field("is_empty", VALUE_WIDTH'(want.is_empty),
                      VALUE_WIDTH'(out_data.is_empty));
        compare_field("is_full", VALUE_WIDTH'(want.is_full),
                      VALUE_WIDTH'(out_data.is_full));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog. Any taken beat, any result and any register write count as
  // progress; a long run of cycles without one of them means the block hung.
  // ---------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** circular_deque_buffer_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Inputs change on the falling edge only.
  // ---------------------------------------------------------------------------

  // Presents one operation beat and holds it until the block takes it. The
  // predictor runs at the accepting edge. A typed-in view, where given, is the
  // one expected; the predictor still runs so that its state stays in step.
  task automatic issue_op(input in_item_t beat, input bit typed, input out_item_t typed_view);
    out_item_t predicted;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = deque_step(beat);
    deque_view_q.push_back(typed ? typed_view : predicted);
  endtask

  // Leaves start low for the given number of cycles. With zero, start stays
  // high and the next beat follows back to back.
  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Most gaps are short, a few are long enough to let the block go quiet.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Writes the capacity register once the block is idle. Every beat yields a
  // result, so an empty list of owed views means nothing is left in flight.
  task automatic write_capacity(input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (deque_view_q.size() != 0) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_capacity(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Push values lean on the extremes now and then; the rest are uniform.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Draws one operation. The push and pop shares steer the fill level, so a
  // phase can drive the deque to full, drain it, or hover in between.
  function automatic in_item_t pick_beat(input int push_pct, input int pop_pct);
    in_item_t beat;
    int       r;
    r = $urandom_range(0, 99);
    beat.push_value = pick_value();
    if (r < push_pct) begin
      beat.opcode = $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
    end else if (r < push_pct + pop_pct) begin
      beat.opcode = $urandom_range(0, 1) ? OP_POP_TAIL : OP_POP_HEAD;
    end else if (r < 98) begin
      beat.opcode = OP_QUERY;
    end else begin
      beat.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    return beat;
  endfunction

  // Capacity settings for the random phases. Small rings wrap and fill often;
  // zero, values past the store depth and junk in the upper bits check the
  // clamp.
  function automatic logic [CFG_DATA_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'd2;
      7:       return STORE_DEPTH;
      8:       return $urandom;
      9:       return $urandom_range(17, 300);
      default: return $urandom_range(3, 16);
    endcase
  endfunction

  int random_beats;

  // One random phase. About one phase in four runs with no gaps at all.
  task automatic run_phase(input int beats, input int push_pct, input int pop_pct);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    repeat (beats) begin
      issue_op(pick_beat(push_pct, pop_pct), 1'b0, '0);
      random_beats++;
      if (!burst) idle_for(pick_gap());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Each row is either a capacity write or one operation beat.
  // Rows whose view is plain to see (the empty deque, a refused beat, a ring
  // of one) carry it typed in; the others lean on the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_DATA_W-1:0] cfg_value;
    in_item_t              beat;
    bit                    typed;
    out_item_t             view;
  } plan_row_t;

  plan_row_t plan_q [$];

  task automatic add_cfg(input logic [CFG_DATA_W-1:0] value);
    plan_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    plan_q.push_back(row);
  endtask

  task automatic add_op(input logic [2:0] op, input logic [VALUE_WIDTH-1:0] value);
    plan_row_t row;
    row                 = '0;
    row.beat.opcode     = op;
    row.beat.push_value = value;
    plan_q.push_back(row);
  endtask

  task automatic add_typed(input logic [2:0] op, input logic [VALUE_WIDTH-1:0] value,
                           input bit acc, input logic [VALUE_WIDTH-1:0] hv,
                           input logic [VALUE_WIDTH-1:0] tv, input bit emp, input bit ful);
    plan_row_t row;
    row                 = '0;
    row.beat.opcode     = op;
    row.beat.push_value = value;
    row.typed           = 1'b1;
    row.view.accepted   = acc;
    row.view.head_value = hv;
    row.view.tail_value = tv;
    row.view.is_empty   = emp;
    row.view.is_full    = ful;
    plan_q.push_back(row);
  endtask

  task automatic build_plan();
    // Fresh out of reset the deque is empty at full depth: queries succeed,
    // pops on the empty deque and meaningless opcodes are refused.
    add_typed(OP_QUERY,     32'h1111_1111, 1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    add_typed(OP_POP_HEAD,  32'h0000_0000, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    add_typed(OP_POP_TAIL,  32'hFFFF_FFFF, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    add_typed(OP_UNUSED_LO, 32'h1234_5678, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    // The extreme values from both ends; the head push wraps to the top slot.
    add_typed(OP_PUSH_HEAD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_typed(OP_PUSH_TAIL, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    add_op(OP_UNUSED_MID, 32'hDEAD_BEEF);
    add_op(OP_UNUSED_HI,  32'hFFFF_FFFF);
    add_op(OP_POP_HEAD,   32'h0000_0000);
    add_op(OP_POP_TAIL,   32'h0000_0000);
    // A written zero becomes a ring of one: the first push fills it and the
    // next pushes are refused. A stored all-ones word must not read as empty.
    add_cfg('0);
    add_typed(OP_PUSH_TAIL, 32'hFFFF_FFFF, 1'b1, EMPTY_WORD, EMPTY_WORD, 1'b0, 1'b1);
    add_typed(OP_PUSH_HEAD, 32'h0000_0000, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b0, 1'b1);
    add_typed(OP_PUSH_TAIL, 32'h5A5A_5A5A, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b0, 1'b1);
    add_typed(OP_POP_TAIL,  32'h0000_0000, 1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    // A ring of two, filled from the head side and drained from the tail.
    add_cfg(32'd2);
    add_op(OP_PUSH_HEAD, 32'h0000_0001);
    add_op(OP_PUSH_HEAD, 32'h7FFF_FFFF);
    add_op(OP_PUSH_TAIL, 32'h0000_0000);
    add_op(OP_QUERY,     32'h0000_0000);
    add_op(OP_POP_TAIL,  32'h0000_0000);
    add_op(OP_POP_TAIL,  32'h0000_0000);
    add_op(OP_POP_HEAD,  32'h0000_0000);
    // All ones keeps 0x7FF after masking, which clamps to the store depth.
    add_cfg(32'hFFFF_FFFF);
    add_op(OP_PUSH_TAIL, 32'h8000_0000);
    add_op(OP_PUSH_HEAD, 32'h1234_5678);
    add_op(OP_POP_HEAD,  32'h0000_0000);
    add_op(OP_POP_HEAD,  32'h0000_0000);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    random_beats = 0;
    for (int i = 0; i < STORE_DEPTH; i++) ring_store[PW'(i)] = '0;
    apply_capacity(STORE_DEPTH);
    build_plan();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        write_capacity(plan_q[i].cfg_value);
      end else begin
        issue_op(plan_q[i].beat, plan_q[i].typed, plan_q[i].view);
        idle_for(pick_gap());
      end
    end

    // One long push-heavy phase at full depth, so that the deque fills the
    // whole store and the full-push refusal is seen at the largest size.
    write_capacity(STORE_DEPTH);
    run_phase(1200, 95, 3);

    // Then short phases over many capacities, each with its own fill bias.
    while (random_beats < RANDOM_BEATS) begin
      write_capacity(pick_capacity());
      case ($urandom_range(0, 2))
        0:       run_phase($urandom_range(40, 120), 70, 20);
        1:       run_phase($urandom_range(40, 120), 20, 70);
        default: run_phase($urandom_range(40, 120), 45, 45);
      endcase
    end

    // Drain: wait for every owed result, then a few more cycles to catch any
    // stray strobe.
    @(negedge clk);
    start <= 1'b0;
    while (deque_view_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && deque_view_q.size() == 0) begin
      $display("** circular_deque_buffer_unit: PASSED **");
    end else begin
      $display("** circular_deque_buffer_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cdb_pkg.sv
hdl/cdb_store.sv
hdl/cdb_ctrl.sv
hdl/circular_deque_buffer_unit.sv
hdl/cdb_chk.sv
bench/circular_deque_buffer_unit_tb.sv
